[hdl/circular_queue_defines.svh]
// Assertion macros used by the circular queue back end (cq_back).
`ifndef CIRCULAR_QUEUE_DEFINES_SVH
`define CIRCULAR_QUEUE_DEFINES_SVH

`ifndef SYNTHESIS

`define CQ_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("circular_queue assertion failed");

`define CQ_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("circular_queue assertion failed");

`else

`define CQ_ASSERT_IMP(label, ante, cons)

`define CQ_ASSERT_NXT(label, ante, cons)

`endif

`endif

[hdl/cq_pkg.sv]
package cq_pkg;

  typedef enum logic [1:0] {
    OP_ENQ  = 2'd0,
    OP_DEQ  = 2'd1,
    OP_PEEK = 2'd2,
    OP_DISP = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK  = 2'd0,
    ST_OVF = 2'd1,
    ST_UNF = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_EXEC = 2'b01,
    S_DISP = 2'b10
  } bk_state_e;

  typedef struct packed {
    logic [1:0]         operation;
    logic signed [31:0] value;
  } in_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] data;
    logic               last;
  } out_t;

  typedef struct packed {
    logic               valid;
    op_e                op;
    logic signed [31:0] value;
  } cmd_t;

endpackage

[hdl/circular_queue.sv]
// Items wait in cq_front's buffer; results leave through the cq_back output register.
// Enqueue, dequeue and peek each give one result; output back-pressure stalls the stage.
// Display holds the execution stage and gives one result per stored word, at least one.
// The execution stage reads storage through a single registered memory port.
// Reset clears pointers, occupancy and handshake state; storage contents are undefined
// after reset and an entry is never read before it is written.
module circular_queue #(
  parameter int DEPTH = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_stall_o,
  input  cq_pkg::in_t  in_item_i,
  output logic         out_valid_o,
  input  logic         out_stall_i,
  output cq_pkg::out_t out_item_o
);

  cq_pkg::cmd_t cmd;
  logic         pop;

  cq_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .cmd_o      (cmd),
    .pop_i      (pop)
  );

  cq_back #(
    .DEPTH (DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule

[hdl/cq_front.sv]
module cq_front (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_stall_o,
  input  cq_pkg::in_t  in_item_i,
  output cq_pkg::cmd_t cmd_o,
  input  logic         pop_i
);

  cq_pkg::in_t entry_q [2];
  logic        wr_q, wr_d;
  logic        rd_q, rd_d;
  logic [1:0]  cnt_q, cnt_d;
  logic        push;

  assign in_stall_o = cnt_q[1];
  assign push       = in_valid_i && !in_stall_o;

  always_comb begin
    cmd_o.valid = (cnt_q != 2'd0);
    cmd_o.op    = cq_pkg::op_e'(entry_q[rd_q].operation);
    cmd_o.value = entry_q[rd_q].value;
  end

  always_comb begin
    wr_d  = push ? ~wr_q : wr_q;
    rd_d  = pop_i ? ~rd_q : rd_q;
    cnt_d = cnt_q;
    if (push && !pop_i) begin
      cnt_d = cnt_q + 2'd1;
    end else if (!push && pop_i) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_q] <= in_item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

[hdl/cq_back.sv]
`include "circular_queue_defines.svh"

module cq_back #(
  parameter int DEPTH = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  cq_pkg::cmd_t cmd_i,
  output logic         pop_o,
  output logic         out_valid_o,
  input  logic         out_stall_i,
  output cq_pkg::out_t out_item_o
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  function automatic logic [PW-1:0] wrap_next(input logic [PW-1:0] idx);
    wrap_next = (idx == PW'(DEPTH - 1)) ? '0 : idx + 1'b1;
  endfunction

  logic signed [31:0] mem [DEPTH];
  logic signed [31:0] rdata_q;

  cq_pkg::bk_state_e state_q, state_d;
  logic [PW-1:0]     head_q, head_d;
  logic [PW-1:0]     tail_q, tail_d;
  logic [PW-1:0]     ptr_q, ptr_d;
  logic [CW-1:0]     cnt_q, cnt_d;
  logic [CW-1:0]     left_q, left_d;

  logic              out_valid_q;
  cq_pkg::status_e   status_q, res_status;
  logic              last_q, res_last;
  logic              mem_q, res_mem;

  logic              out_free, issue, wr_en, rd_en, full, empty;
  logic [PW-1:0]     rd_addr;

  assign out_free = !out_valid_q || !out_stall_i;
  assign full     = (cnt_q == CW'(DEPTH));
  assign empty    = (cnt_q == '0);

  always_comb begin
    state_d    = state_q;
    head_d     = head_q;
    tail_d     = tail_q;
    ptr_d      = ptr_q;
    cnt_d      = cnt_q;
    left_d     = left_q;
    issue      = 1'b0;
    pop_o      = 1'b0;
    wr_en      = 1'b0;
    rd_en      = 1'b0;
    rd_addr    = head_q;
    res_status = cq_pkg::ST_OK;
    res_last   = 1'b0;
    res_mem    = 1'b0;
    case (state_q)
      cq_pkg::S_EXEC: begin
        if (cmd_i.valid && out_free) begin
          issue = 1'b1;
          case (cmd_i.op)
            cq_pkg::OP_ENQ: begin
              pop_o    = 1'b1;
              res_last = 1'b1;
              if (full) begin
                res_status = cq_pkg::ST_OVF;
              end else begin
                wr_en  = 1'b1;
                tail_d = wrap_next(tail_q);
                cnt_d  = cnt_q + 1'b1;
              end
            end
            cq_pkg::OP_DEQ, cq_pkg::OP_PEEK: begin
              pop_o    = 1'b1;
              res_last = 1'b1;
              if (empty) begin
                res_status = cq_pkg::ST_UNF;
              end else begin
                rd_en   = 1'b1;
                res_mem = 1'b1;
                if (cmd_i.op == cq_pkg::OP_DEQ) begin
                  head_d = wrap_next(head_q);
                  cnt_d  = cnt_q - 1'b1;
                end
              end
            end
            cq_pkg::OP_DISP: begin
              if (empty) begin
                pop_o      = 1'b1;
                res_last   = 1'b1;
                res_status = cq_pkg::ST_UNF;
              end else begin
                rd_en   = 1'b1;
                res_mem = 1'b1;
                if (cnt_q == CW'(1)) begin
                  pop_o    = 1'b1;
                  res_last = 1'b1;
                end else begin
                  state_d = cq_pkg::S_DISP;
                  ptr_d   = wrap_next(head_q);
                  left_d  = cnt_q - 1'b1;
                end
              end
            end
            default: begin
              issue = 1'b0;
            end
          endcase
        end
      end
      cq_pkg::S_DISP: begin
        if (out_free) begin
          issue   = 1'b1;
          rd_en   = 1'b1;
          rd_addr = ptr_q;
          res_mem = 1'b1;
          ptr_d   = wrap_next(ptr_q);
          left_d  = left_q - 1'b1;
          if (left_q == CW'(1)) begin
            res_last = 1'b1;
            pop_o    = 1'b1;
            state_d  = cq_pkg::S_EXEC;
          end
        end
      end
      default: begin
        state_d = cq_pkg::S_EXEC;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[tail_q] <= cmd_i.value;
    end
    if (rd_en) begin
      rdata_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= cq_pkg::S_EXEC;
      head_q      <= '0;
      tail_q      <= '0;
      ptr_q       <= '0;
      cnt_q       <= '0;
      left_q      <= '0;
      out_valid_q <= 1'b0;
      status_q    <= cq_pkg::ST_OK;
      last_q      <= 1'b0;
      mem_q       <= 1'b0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      tail_q  <= tail_d;
      ptr_q   <= ptr_d;
      cnt_q   <= cnt_d;
      left_q  <= left_d;
      if (out_free) begin
        out_valid_q <= issue;
        status_q    <= res_status;
        last_q      <= res_last;
        mem_q       <= res_mem;
      end
    end
  end

  assign out_valid_o       = out_valid_q;
  assign out_item_o.status = status_q;
  assign out_item_o.data   = mem_q ? rdata_q : '0;
  assign out_item_o.last   = last_q;

  `CQ_ASSERT_IMP(a_cnt_bound, 1'b1, cnt_q <= CW'(DEPTH))
  `CQ_ASSERT_IMP(a_disp_left, state_q == cq_pkg::S_DISP, left_q != '0)
  `CQ_ASSERT_NXT(a_enq_count, wr_en, cnt_q == $past(cnt_q) + CW'(1))

endmodule

[verif/tb_top.sv]
module tb_top;

  localparam int DEPTH = 16;
  localparam int IDLE_LIMIT = 1000;
  localparam int LONG_HOLD = 120;

  logic clk_i;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  cq_pkg::in_t  in_item_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  cq_pkg::out_t out_item_o;

  circular_queue #(
    .DEPTH(DEPTH)
  ) u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

  cq_pkg::in_t  op_stream[$];
  cq_pkg::out_t due_results[$];

  logic signed [31:0] words[DEPTH];
  int unsigned head_slot = 0;
  int unsigned tail_slot = 0;
  int unsigned fill_level = 0;

  int  mismatches = 0;
  int  idle_cycles = 0;
  bit  in_taken = 1'b0;
  bit  offering = 1'b0;
  int  burst_left = 0;
  int  gap_left = 0;
  bit  hold_req = 1'b0;
  int  hold_left = 0;
  int  rx_mode = 0;
  int  rx_mode_left = 0;
  int  rx_phase = 0;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic void predict_queue_op(cq_pkg::in_t item);
    cq_pkg::out_t r;
    int unsigned  n;
    int unsigned  slot;
    r = '0;
    r.last = 1'b1;
    if (item.operation == cq_pkg::OP_ENQ) begin
      if (fill_level == DEPTH) begin
        r.status = cq_pkg::ST_OVF;
      end else begin
        words[tail_slot] = item.value;
        tail_slot = (tail_slot + 1) % DEPTH;
        fill_level++;
        r.status = cq_pkg::ST_OK;
      end
      due_results.push_back(r);
    end else if (fill_level == 0) begin
      r.status = cq_pkg::ST_UNF;
      due_results.push_back(r);
    end else if (item.operation == cq_pkg::OP_DISP) begin
      slot = head_slot;
      for (n = 0; n < fill_level; n++) begin
        r.status = cq_pkg::ST_OK;
        r.data = words[slot];
        r.last = (n + 1 == fill_level);
        due_results.push_back(r);
        slot = (slot + 1) % DEPTH;
      end
    end else begin
      r.status = cq_pkg::ST_OK;
      r.data = words[head_slot];
      due_results.push_back(r);
      if (item.operation == cq_pkg::OP_DEQ) begin
        head_slot = (head_slot + 1) % DEPTH;
        fill_level--;
      end
    end
  endfunction

  function automatic logic signed [31:0] rand_word();
    case ($urandom_range(0, 7))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'h0000_0000;
      3: return 32'hFFFF_FFFF;
      default: return $urandom();
    endcase
  endfunction

  function automatic void add_item(cq_pkg::op_e op, logic signed [31:0] v);
    cq_pkg::in_t it;
    it.operation = op;
    it.value = v;
    op_stream.push_back(it);
  endfunction

  task automatic wait_drained();
    while (op_stream.size() > 0 || offering || due_results.size() > 0) @(posedge clk_i);
  endtask

  // Acceptance and result checking, both sampled at the rising edge.
  always @(posedge clk_i) begin
    cq_pkg::out_t want;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        predict_queue_op(in_item_i);
        in_taken = 1'b1;
      end
      if (out_valid_o && !out_stall_i) begin
        if (due_results.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected item, status %0d data %0d last %0d", $time,
                   out_item_o.status, out_item_o.data, out_item_o.last);
        end else begin
          want = due_results.pop_front();
          if (out_item_o !== want) begin
            mismatches++;
            $display("%0t: expected status %0d data %0d last %0d, got status %0d data %0d last %0d",
                     $time, want.status, want.data, want.last,
                     out_item_o.status, out_item_o.data, out_item_o.last);
          end
        end
      end
    end
  end

  // Sender: bursts of random length separated by random gaps.
  always @(negedge clk_i) begin
    if (in_taken) begin
      in_taken = 1'b0;
      offering = 1'b0;
      void'(op_stream.pop_front());
    end
    if (!offering) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid_i <= 1'b0;
      end else if (rst_ni && op_stream.size() > 0) begin
        in_item_i <= op_stream[0];
        in_valid_i <= 1'b1;
        offering = 1'b1;
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 12);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
        end else begin
          burst_left--;
        end
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Receiver: switches between stall patterns, with long hold-offs on request.
  always @(negedge clk_i) begin
    if (hold_req) begin
      hold_req = 1'b0;
      hold_left = LONG_HOLD;
    end
    if (rx_mode_left == 0) begin
      rx_mode = $urandom_range(0, 3);
      rx_mode_left = $urandom_range(20, 60);
    end else begin
      rx_mode_left--;
    end
    rx_phase++;
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      case (rx_mode)
        0: out_stall_i <= 1'b0;
        1: out_stall_i <= ($urandom_range(0, 9) < 3);
        2: out_stall_i <= (rx_phase % 3 == 0);
        default: out_stall_i <= ($urandom_range(0, 9) < 7);
      endcase
    end
  end

  initial begin
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("** circular_queue: FAILED **");
    $finish;
  end

  initial begin
    int          k;
    int          pick;
    bit          fill_bias;
    cq_pkg::op_e op;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Empty queue, extreme words, a full queue with wrapped pointers and an overflow.
    add_item(cq_pkg::OP_PEEK, rand_word());
    add_item(cq_pkg::OP_DEQ, rand_word());
    add_item(cq_pkg::OP_DISP, rand_word());
    add_item(cq_pkg::OP_ENQ, 32'h8000_0000);
    add_item(cq_pkg::OP_ENQ, 32'h7FFF_FFFF);
    add_item(cq_pkg::OP_ENQ, 32'h5555_5555);
    add_item(cq_pkg::OP_ENQ, 32'hAAAA_AAAA);
    add_item(cq_pkg::OP_PEEK, rand_word());
    add_item(cq_pkg::OP_DISP, rand_word());
    add_item(cq_pkg::OP_DEQ, rand_word());
    add_item(cq_pkg::OP_DEQ, rand_word());
    for (k = 0; k < 14; k++) add_item(cq_pkg::OP_ENQ, rand_word());
    add_item(cq_pkg::OP_ENQ, rand_word());
    add_item(cq_pkg::OP_DISP, rand_word());
    wait_drained();

    hold_req = 1'b1;
    fill_bias = 1'b1;
    for (k = 0; k < 83; k++) begin
      if (k % 20 == 0) fill_bias = $urandom_range(0, 1);
      pick = $urandom_range(0, 99);
      if (fill_bias) begin
        op = (pick < 72) ? cq_pkg::OP_ENQ :
             (pick < 84) ? cq_pkg::OP_DEQ :
             (pick < 93) ? cq_pkg::OP_PEEK : cq_pkg::OP_DISP;
      end else begin
        op = (pick < 25) ? cq_pkg::OP_ENQ :
             (pick < 70) ? cq_pkg::OP_DEQ :
             (pick < 86) ? cq_pkg::OP_PEEK : cq_pkg::OP_DISP;
      end
      add_item(op, rand_word());
    end
    while (op_stream.size() > 40) @(posedge clk_i);
    hold_req = 1'b1;
    wait_drained();
    repeat (10) @(posedge clk_i);

    if (mismatches == 0 && due_results.size() == 0) begin
      $display("** circular_queue: PASSED **");
    end else begin
      $display("** circular_queue: FAILED **");
    end
    $finish;
  end

endmodule
